/* hw/rtl/chr_pkg.sv */
// chr_pkg: shared types, mode/status codes and size defaults for the hash ring core.
// No dependencies; imported by chr_cell, chr_or_tree and consistent_hash_ring_core.
package chr_pkg;

   localparam int unsigned RING_DEPTH_DEF = 1024;
   localparam int unsigned NODE_COUNT_DEF = 64;
   localparam int unsigned NODE_W         = 6;
   localparam int unsigned NODE_IDS       = 64;

   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_LOOKUP = 3'd2;
   localparam logic [2:0] MODE_READ   = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   localparam logic [2:0] ST_DONE   = 3'd0;
   localparam logic [2:0] ST_DUP    = 3'd1;
   localparam logic [2:0] ST_FULL   = 3'd2;
   localparam logic [2:0] ST_ABSENT = 3'd3;
   localparam logic [2:0] ST_EMPTY  = 3'd4;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] point_hash;
      logic [5:0]         node_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  owner_node;
      logic [31:0] node_count;
      logic [31:0] request_total;
   } rsp_type;

   // Per-cycle command broadcast to every ring cell.
   typedef struct packed {
      logic cmp_en;
      logic ins;
      logic rem;
   } cell_cmd_type;

   // Search summary of one cell or one subtree.
   typedef struct packed {
      logic              any_ge;
      logic              any_eq;
      logic [NODE_W-1:0] owner;
   } leaf_type;

endpackage

/* hw/rtl/consistent_hash_ring_core.sv */
// consistent_hash_ring_core: sorted ring of point hashes in a chain of cells plus node counters.
// A beat steps through compare, OR tree wait, action, counter read, update and output states,
// the wait set by the registered OR tree that summarizes the cell compares; one beat in flight.
// A new beat is stalled by req_stall until the sequencer is back in idle.
// A new request beat is taken while a finished response beat still waits to be taken.
// Synchronous active-high reset empties the ring and zeroes all counters at once.
module consistent_hash_ring_core import chr_pkg::*; #(
   parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
   parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
   localparam int unsigned RAW    = $clog2(RING_DEPTH);
   localparam int unsigned TCW    = $clog2(RAW + 1);
   localparam int unsigned CNT_AW = $clog2(NODE_COUNT);

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;
   localparam logic [2:0] S_TREE = 3'd2;
   localparam logic [2:0] S_ACT  = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_UPD  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [TCW-1:0]     tcnt_ff, tcnt_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [31:0]        total_ff, total_in;
   req_type            op_ff;
   logic [2:0]         status_ff, status_in;
   logic [NODE_W-1:0]  owner_ff, owner_in;
   logic [31:0]        count_ff, count_in;
   logic [CNT_AW-1:0]  addr_ff, addr_in;
   logic               counted_ff, counted_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   cell_cmd_type       cmd;

   // node counter store, with valid bits standing in for the reset clear
   logic [31:0]        cnt_mem [NODE_COUNT];
   logic               cnt_vld_ff [NODE_COUNT];
   logic [31:0]        cnt_rd_ff;
   logic               vld_rd_ff;
   logic [31:0]        cnt_cur;
   logic [31:0]        cnt_inc;
   logic               cnt_we;
   logic               vld_clr;
   logic [CNT_AW-1:0]  mod_tab [NODE_IDS];

   // ring chain wiring
   logic signed [31:0] hash_w  [RING_DEPTH];
   logic [NODE_W-1:0]  own_w   [RING_DEPTH];
   logic               ge_w    [RING_DEPTH];
   leaf_type           leaf_w  [RING_DEPTH];
   leaf_type           root;
   logic [NODE_W-1:0]  pick;

   genvar g;
   generate
      // node id to counter slot, worked out at elaboration
      for (g = 0; g < NODE_IDS; g++) begin : g_mod
         assign mod_tab[g] = CNT_AW'(g % NODE_COUNT);
      end
      for (g = 0; g < RING_DEPTH; g++) begin : g_cell
         logic               p_ge;
         logic signed [31:0] p_hash;
         logic [NODE_W-1:0]  p_own;
         logic signed [31:0] n_hash;
         logic [NODE_W-1:0]  n_own;
         if (g == 0) begin : g_head
            assign p_ge   = 1'b0;
            assign p_hash = '0;
            assign p_own  = '0;
         end else begin : g_mid
            assign p_ge   = ge_w[g-1];
            assign p_hash = hash_w[g-1];
            assign p_own  = own_w[g-1];
         end
         if (g == RING_DEPTH - 1) begin : g_tail
            assign n_hash = '0;
            assign n_own  = '0;
         end else begin : g_body
            assign n_hash = hash_w[g+1];
            assign n_own  = own_w[g+1];
         end
         chr_cell #(
            .FILL_W (FILL_W),
            .IDX    (g)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .fill       (fill_ff),
            .key        (op_ff.point_hash),
            .new_owner  (op_ff.node_id),
            .prev_ge    (p_ge),
            .prev_hash  (p_hash),
            .prev_owner (p_own),
            .next_hash  (n_hash),
            .next_owner (n_own),
            .hash_out   (hash_w[g]),
            .owner_out  (own_w[g]),
            .ge_out     (ge_w[g]),
            .leaf_out   (leaf_w[g])
         );
      end
   endgenerate

   chr_or_tree #(
      .LEAVES (RING_DEPTH)
   ) u_tree (
      .clock  (clock),
      .leaves (leaf_w),
      .root   (root)
   );

   // no point at or above the key: wrap to the lowest point
   assign pick = root.any_ge ? root.owner : own_w[0];

   assign cnt_cur = vld_rd_ff ? cnt_rd_ff : '0;
   assign cnt_inc = (cnt_cur == 32'hFFFF_FFFF) ? cnt_cur : cnt_cur + 32'd1;

   always_comb begin
      state_in   = state_ff;
      tcnt_in    = tcnt_ff;
      fill_in    = fill_ff;
      total_in   = total_ff;
      status_in  = status_ff;
      owner_in   = owner_ff;
      count_in   = count_ff;
      addr_in    = addr_ff;
      counted_in = counted_ff;
      cmd        = '0;
      cnt_we     = 1'b0;
      vld_clr    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // latch every cell's compare against the key
            cmd.cmp_en = 1'b1;
            tcnt_in    = TCW'(RAW - 1);
            state_in   = S_TREE;
         end
         S_TREE: begin
            if (tcnt_ff == '0) begin
               state_in = S_ACT;
            end else begin
               tcnt_in = tcnt_ff - TCW'(1);
            end
         end
         S_ACT: begin
            status_in  = ST_DONE;
            owner_in   = '0;
            count_in   = '0;
            counted_in = 1'b0;
            addr_in    = mod_tab[op_ff.node_id];
            case (op_ff.mode)
               MODE_INSERT: begin
                  if (root.any_eq) begin
                     status_in = ST_DUP;
                  end else if (fill_ff == FILL_W'(RING_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.ins = 1'b1;
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
               MODE_REMOVE: begin
                  if (root.any_eq) begin
                     cmd.rem = 1'b1;
                     fill_in = fill_ff - FILL_W'(1);
                  end else begin
                     status_in = ST_ABSENT;
                  end
               end
               MODE_LOOKUP: begin
                  if (fill_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     owner_in   = pick;
                     addr_in    = mod_tab[pick];
                     counted_in = 1'b1;
                  end
               end
               MODE_CLEAR: begin
                  vld_clr = 1'b1;
               end
               default: begin
               end
            endcase
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (counted_ff) begin
               cnt_we   = 1'b1;
               count_in = cnt_inc;
               total_in = (total_ff == 32'hFFFF_FFFF) ? total_ff : total_ff + 32'd1;
            end else if (op_ff.mode == MODE_READ) begin
               count_in = cnt_cur;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the response register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         counted_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         total_ff   <= total_in;
         counted_ff <= counted_in;
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tcnt_ff   <= tcnt_in;
      status_ff <= status_in;
      owner_ff  <= owner_in;
      count_ff  <= count_in;
      addr_ff   <= addr_in;
      if (state_ff == S_IDLE && req_valid) begin
         op_ff <= req_data;
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.owner_node    <= owner_ff;
         rsp_ff.node_count    <= count_ff;
         rsp_ff.request_total <= total_ff;
      end
   end

   // counter store: registered read, single write port
   always_ff @(posedge clock) begin
      cnt_rd_ff <= cnt_mem[addr_ff];
      if (cnt_we) begin
         cnt_mem[addr_ff] <= cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODE_COUNT; i++) begin
            cnt_vld_ff[i] <= 1'b0;
         end
      end else if (cnt_we) begin
         cnt_vld_ff[addr_ff] <= 1'b1;
      end else if (vld_clr) begin
         cnt_vld_ff[addr_in] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      vld_rd_ff <= cnt_vld_ff[addr_ff];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(RING_DEPTH))
      else $error("ring fill beyond depth");

   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> fill_ff == $past(fill_ff) + FILL_W'(1))
      else $error("insert did not grow the ring");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside the output step");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("request total went down");

endmodule

/* hw/rtl/chr_cell.sv */
// chr_cell: one ring slot holding a point hash and its owner, shifting with its neighbors.
// Depends on chr_pkg.
module chr_cell import chr_pkg::*; #(
   parameter int unsigned FILL_W = 11,
   parameter int unsigned IDX    = 0
) (
   input  logic               clock,
   input  cell_cmd_type       cmd,
   input  logic [FILL_W-1:0]  fill,
   input  logic signed [31:0] key,
   input  logic [NODE_W-1:0]  new_owner,
   input  logic               prev_ge,
   input  logic signed [31:0] prev_hash,
   input  logic [NODE_W-1:0]  prev_owner,
   input  logic signed [31:0] next_hash,
   input  logic [NODE_W-1:0]  next_owner,
   output logic signed [31:0] hash_out,
   output logic [NODE_W-1:0]  owner_out,
   output logic               ge_out,
   output leaf_type           leaf_out
);

   logic signed [31:0] hash_ff;
   logic [NODE_W-1:0]  owner_ff;
   logic               ge_ff;
   logic               eq_ff;
   logic               occupied;
   logic               at_fill;

   assign occupied = FILL_W'(IDX) < fill;
   assign at_fill  = FILL_W'(IDX) == fill;

   always_ff @(posedge clock) begin
      if (cmd.cmp_en) begin
         ge_ff <= occupied && (hash_ff >= key);
         eq_ff <= occupied && (hash_ff == key);
      end
      if (cmd.ins) begin
         // slots past the insert point take their left neighbor
         if (prev_ge) begin
            hash_ff  <= prev_hash;
            owner_ff <= prev_owner;
         end else if (ge_ff || at_fill) begin
            hash_ff  <= key;
            owner_ff <= new_owner;
         end
      end else if (cmd.rem) begin
         if (ge_ff) begin
            hash_ff  <= next_hash;
            owner_ff <= next_owner;
         end
      end
   end

   assign hash_out       = hash_ff;
   assign owner_out      = owner_ff;
   assign ge_out         = ge_ff;
   assign leaf_out.any_ge = ge_ff;
   assign leaf_out.any_eq = eq_ff;
   assign leaf_out.owner  = (ge_ff && !prev_ge) ? owner_ff : '0;

endmodule

/* hw/rtl/chr_or_tree.sv */
// chr_or_tree: registered OR-reduction tree over the cell summaries, one level per cycle.
// Depends on chr_pkg.
module chr_or_tree import chr_pkg::*; #(
   parameter int unsigned LEAVES = 1024
) (
   input  logic     clock,
   input  leaf_type leaves [LEAVES],
   output leaf_type root
);

   localparam int unsigned LW = $clog2(LEAVES);
   localparam int unsigned P  = 1 << LW;

   leaf_type nodes [1:2*P-1];

   genvar g;
   generate
      for (g = 0; g < P; g++) begin : g_leaf
         if (g < LEAVES) begin : g_used
            assign nodes[P+g] = leaves[g];
         end else begin : g_pad
            assign nodes[P+g] = '0;
         end
      end
      for (g = 1; g < P; g++) begin : g_node
         leaf_type node_ff;
         always_ff @(posedge clock) begin
            node_ff <= leaf_type'(nodes[2*g] | nodes[2*g+1]);
         end
         assign nodes[g] = node_ff;
      end
   endgenerate

   assign root = nodes[1];

endmodule

/* tb/tb_consistent_hash_ring_core.sv */
// Testbench for consistent_hash_ring_core: directed and random ring edits, lookups and stats.
// Depends on chr_pkg and the core; predicts every response and compares it field by field.
module tb_consistent_hash_ring_core;
   import chr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 1024;
   localparam int NODES     = 64;
   localparam int LIMIT     = 100000;
   localparam int TAIL_WAIT = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   consistent_hash_ring_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // Shadow ring: sorted signed hashes with owners, plus node and total counters.
   logic signed [31:0] ring_hash_q[$];
   logic [5:0]         ring_owner_q[$];
   logic [31:0]        node_hits[NODES];
   logic [31:0]        hit_total;
   rsp_type            pending_rsp[$];

   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // First slot whose hash is at or above h, or the fill count if none.
   function automatic int ring_seek(logic signed [31:0] h);
      int lo, hi, mid;
      lo = 0;
      hi = ring_hash_q.size();
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (ring_hash_q[mid] < h) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic logic [31:0] sat_bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // Apply one request beat to the shadow ring and return its response.
   function automatic rsp_type ring_apply(req_type r);
      rsp_type o;
      int      pos;
      int      fill;
      logic [5:0] nd;
      o = '0;
      fill = ring_hash_q.size();
      nd = 6'(r.node_id % NODES);
      case (r.mode)
         MODE_INSERT: begin
            pos = ring_seek(r.point_hash);
            if (pos < fill && ring_hash_q[pos] == r.point_hash) o.status = ST_DUP;
            else if (fill >= DEPTH) o.status = ST_FULL;
            else begin
               ring_hash_q.insert(pos, r.point_hash);
               ring_owner_q.insert(pos, r.node_id);
            end
         end
         MODE_REMOVE: begin
            pos = ring_seek(r.point_hash);
            if (pos < fill && ring_hash_q[pos] == r.point_hash) begin
               ring_hash_q.delete(pos);
               ring_owner_q.delete(pos);
            end else o.status = ST_ABSENT;
         end
         MODE_LOOKUP: begin
            if (fill == 0) o.status = ST_EMPTY;
            else begin
               pos = ring_seek(r.point_hash);
               if (pos >= fill) pos = 0;
               o.owner_node = ring_owner_q[pos];
               node_hits[o.owner_node % NODES] = sat_bump(node_hits[o.owner_node % NODES]);
               hit_total = sat_bump(hit_total);
               o.node_count = node_hits[o.owner_node % NODES];
            end
         end
         MODE_READ:  o.node_count = node_hits[nd];
         MODE_CLEAR: node_hits[nd] = '0;
         default: ;
      endcase
      o.request_total = hit_total;
      return o;
   endfunction

   // Drive one beat and hold it until accepted; predict at acceptance.
   task automatic send_beat(logic [2:0] mode, logic signed [31:0] h, logic [5:0] nid);
      req_type r;
      r.mode = mode;
      r.point_hash = h;
      r.node_id = nid;
      // Drop valid for each idle cycle; otherwise the next beat follows right away.
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.insert(pending_rsp.size(), ring_apply(r));
   endtask

   // Receiver stall pattern.
   always @(posedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Response checker.
   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status || rsp_data.owner_node !== want.owner_node ||
                rsp_data.node_count !== want.node_count ||
                rsp_data.request_total !== want.request_total) begin
               errors++;
               // fields in order: status, owner, node count, total
               if (errors <= 10)
                  $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           want.status, want.owner_node, want.node_count, want.request_total,
                           rsp_data.status, rsp_data.owner_node, rsp_data.node_count,
                           rsp_data.request_total);
            end
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_hash();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel == 0) return 32'sh8000_0000;
      if (sel == 1) return 32'sh7FFF_FFFF;
      if (sel < 5 && ring_hash_q.size() > 0)
         return ring_hash_q[$urandom_range(ring_hash_q.size() - 1)];
      if (sel < 7) return $signed($urandom_range(63)) - 32;
      return $urandom;
   endfunction

   // Extremes, every mode, empty ring, absent point, duplicate, wrap, bad modes.
   task automatic test_directed();
      send_beat(MODE_LOOKUP, 32'sd0, 6'd0);
      send_beat(MODE_REMOVE, 32'sd5, 6'd0);
      send_beat(MODE_INSERT, 32'sh8000_0000, 6'd63);
      send_beat(MODE_INSERT, 32'sh7FFF_FFFF, 6'd1);
      send_beat(MODE_INSERT, 32'sd0, 6'd42);
      send_beat(MODE_INSERT, 32'sd0, 6'd7);
      send_beat(MODE_INSERT, -32'sd1, 6'd21);
      send_beat(MODE_LOOKUP, 32'sh8000_0000, 6'd0);
      send_beat(MODE_LOOKUP, 32'sd1, 6'd0);
      send_beat(MODE_LOOKUP, -32'sd2, 6'd0);
      send_beat(MODE_LOOKUP, 32'sh7FFF_FFFF, 6'd0);
      send_beat(MODE_REMOVE, 32'sh7FFF_FFFF, 6'd0);
      send_beat(MODE_LOOKUP, 32'sh7FFF_FFFF, 6'd0);
      send_beat(MODE_READ, 32'sh5A5A_5A5A, 6'd63);
      send_beat(MODE_READ, 32'sd0, 6'd42);
      send_beat(MODE_CLEAR, 32'sd0, 6'd63);
      send_beat(MODE_READ, 32'sd0, 6'd63);
      send_beat(3'd5, 32'shFFFF_FFFF, 6'd63);
      send_beat(3'd6, 32'sd0, 6'd0);
      send_beat(3'd7, 32'sd0, 6'd0);
   endtask

   // Grow a ring of evenly spaced points, probe it, then drain most of it.
   task automatic test_ring_dense();
      int k;
      for (k = 0; k < 60; k++)
         send_beat(MODE_INSERT, $signed(k * 4099 - 2000000), k[5:0]);
      send_beat(MODE_INSERT, 32'sd3, 6'd9);
      send_beat(MODE_INSERT, 32'sd0, 6'd9);
      send_beat(MODE_LOOKUP, 32'sh7FFF_FFFF, 6'd0);
      while (ring_hash_q.size() > 8)
         send_beat(MODE_REMOVE, ring_hash_q[$urandom_range(ring_hash_q.size() - 1)], 6'd0);
   endtask

   // Mostly lookups and edits against live points, with random noise.
   task automatic test_random(int count);
      int n;
      int unsigned m;
      for (n = 0; n < count; n++) begin
         m = $urandom_range(99);
         if (m < 30) send_beat(MODE_INSERT, pick_hash(), 6'($urandom));
         else if (m < 45) send_beat(MODE_REMOVE, pick_hash(), 6'($urandom));
         else if (m < 80) send_beat(MODE_LOOKUP, pick_hash(), 6'($urandom));
         else if (m < 90) send_beat(MODE_READ, $urandom, 6'($urandom));
         else if (m < 96) send_beat(MODE_CLEAR, $urandom, 6'($urandom));
         else send_beat(3'($urandom_range(7, 5)), $urandom, 6'($urandom));
      end
   endtask

   initial begin
      int k;
      for (k = 0; k < NODES; k++) node_hits[k] = '0;
      hit_total = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 26; recv_idle_pct = 73;
      test_directed();
      test_random(90);
      send_idle_pct = 73; recv_idle_pct = 26;
      test_ring_dense();
      test_random(90);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(90);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

/* consistent_hash_ring_core.f */
hw/rtl/chr_pkg.sv
hw/rtl/chr_cell.sv
hw/rtl/chr_or_tree.sv
hw/rtl/consistent_hash_ring_core.sv
tb/tb_consistent_hash_ring_core.sv
